[hdl/ffha_pkg.sv]
// Package for the first-fit heap allocator: constants, types and state codes.
`default_nettype none
package ffha_pkg;
	localparam int HeapBytes   = 4096;
	localparam int HeaderBytes = 16;
	localparam int MaxBlocks   = 256;
	localparam int IdxW = $clog2(MaxBlocks);
	localparam int CntW = $clog2(MaxBlocks + 1);
	localparam int OffW = 16;
	localparam int SzW  = 16;
	localparam int EntW = OffW + SzW + 1;

	localparam logic [2:0] StAlloc    = 3'd0;
	localparam logic [2:0] StNoFit    = 3'd1;
	localparam logic [2:0] StFreed    = 3'd2;
	localparam logic [2:0] StOutside  = 3'd3;
	localparam logic [2:0] StNotBlock = 3'd4;

	typedef struct packed {
		logic        opcode;
		logic [12:0] request_size;
		logic [12:0] block_address;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [12:0] result_address;
		logic [12:0] freed_size;
	} out_item_t;

	typedef struct packed {
		logic [OffW-1:0] offset;
		logic [SzW-1:0]  size;
		logic            free;
	} entry_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_ALLOC_WR, S_SHU_RD, S_SHU_WR, S_INS_WR,
		S_FREE_RDP, S_FREE_RDN, S_FREE_DEC, S_DEL_RD, S_DEL_WR, S_DONE
	} state_t;

	typedef struct packed {
		state_t st;
	} ctl_t;

	typedef struct packed {
		logic cond;
		logic cond2;
	} sts_t;
endpackage
`default_nettype wire

[hdl/ffha_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module ffha_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(Depth)-1:0] waddr,
	input  wire [Width-1:0]         wdata,
	input  wire [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]        rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[hdl/ffha_ctrl.sv]
// Controller state machine of the heap allocator.
`default_nettype none
module ffha_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  ffha_pkg::sts_t sts,
	output ffha_pkg::ctl_t ctl
);
	ffha_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffha_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// sts.cond/cond2 meaning depends on state; datapath decides branches
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffha_pkg::S_INIT:     state_d = ffha_pkg::S_IDLE;
			ffha_pkg::S_IDLE:     if (start) state_d = sts.cond ? ffha_pkg::S_SCAN_RD
				: (sts.cond2 ? ffha_pkg::S_DONE : ffha_pkg::S_SCAN_RD);
			ffha_pkg::S_SCAN_RD:  state_d = ffha_pkg::S_SCAN_CHK;
			ffha_pkg::S_SCAN_CHK: begin
				if (sts.cond) state_d = sts.cond2 ? ffha_pkg::S_ALLOC_WR : ffha_pkg::S_FREE_RDP;
				else state_d = sts.cond2 ? ffha_pkg::S_DONE : ffha_pkg::S_SCAN_RD;
			end
			ffha_pkg::S_ALLOC_WR: state_d = sts.cond ? ffha_pkg::S_SHU_RD : ffha_pkg::S_DONE;
			ffha_pkg::S_SHU_RD:   state_d = sts.cond ? ffha_pkg::S_SHU_WR : ffha_pkg::S_INS_WR;
			ffha_pkg::S_SHU_WR:   state_d = ffha_pkg::S_SHU_RD;
			ffha_pkg::S_INS_WR:   state_d = ffha_pkg::S_DONE;
			ffha_pkg::S_FREE_RDP: state_d = ffha_pkg::S_FREE_RDN;
			ffha_pkg::S_FREE_RDN: state_d = ffha_pkg::S_FREE_DEC;
			ffha_pkg::S_FREE_DEC: state_d = sts.cond ? ffha_pkg::S_DEL_RD : ffha_pkg::S_DONE;
			ffha_pkg::S_DEL_RD:   state_d = sts.cond ? ffha_pkg::S_DEL_WR : ffha_pkg::S_DONE;
			ffha_pkg::S_DEL_WR:   state_d = ffha_pkg::S_DEL_RD;
			ffha_pkg::S_DONE:     state_d = ffha_pkg::S_IDLE;
			default:              state_d = ffha_pkg::S_IDLE;
		endcase
	end

	assign ctl.st = state_q;

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ffha_pkg::S_DONE |=> state_q == ffha_pkg::S_IDLE) else $error("done");
	a_ins_after: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ffha_pkg::S_INS_WR |-> $past(state_q) == ffha_pkg::S_SHU_RD) else $error("ins");
	a_init: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ffha_pkg::S_INIT |=> state_q == ffha_pkg::S_IDLE) else $error("init");
endmodule
`default_nettype wire

[hdl/ffha_dp.sv]
// Datapath of the heap allocator: block table, counters and result register.
`default_nettype none
module ffha_dp (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  ffha_pkg::in_item_t    in_item,
	input  ffha_pkg::ctl_t        ctl,
	output ffha_pkg::sts_t        sts,
	output logic                  done,
	output ffha_pkg::out_item_t   out_item
);
	localparam logic [ffha_pkg::SzW-1:0] Hdr = ffha_pkg::SzW'(ffha_pkg::HeaderBytes);
	localparam logic [ffha_pkg::CntW-1:0] Full = ffha_pkg::CntW'(ffha_pkg::MaxBlocks);

	ffha_pkg::in_item_t req_q;
	logic [ffha_pkg::CntW-1:0] used_q, i_q;
	logic [ffha_pkg::CntW-1:0] j_q;
	ffha_pkg::entry_t cur_q, prv_q, rest_q;
	logic pf_q, nf_q;
	logic [1:0] ndel_q;
	logic [2:0] stat_q;
	logic [12:0] raddr_q, freed_q;

	logic we;
	logic [ffha_pkg::IdxW-1:0] wa, ra;
	ffha_pkg::entry_t wd, rd;

	ffha_ram #(.Width(ffha_pkg::EntW), .Depth(ffha_pkg::MaxBlocks)) u_ram (
		.clk(clk), .we(we), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd));

	logic [ffha_pkg::SzW-1:0] rq;
	logic hit_a, hit_f, split;
	logic nf_now;
	assign rq = ffha_pkg::SzW'(req_q.request_size);
	assign hit_a = rd.free && rd.size >= rq;
	assign hit_f = (rd.offset + Hdr) == ffha_pkg::SzW'(req_q.block_address);
	assign split = (cur_q.size - rq > Hdr) && (used_q < Full);
	assign nf_now = (i_q + 1'b1 < used_q) && rd.free;

	always_comb begin
		we = 1'b0;
		wa = i_q[ffha_pkg::IdxW-1:0];
		wd = cur_q;
		ra = i_q[ffha_pkg::IdxW-1:0];
		sts = '0;
		case (ctl.st)
			ffha_pkg::S_INIT: begin
				we = 1'b1;
				wa = '0;
				wd.offset = '0;
				wd.size = ffha_pkg::SzW'(ffha_pkg::HeapBytes - ffha_pkg::HeaderBytes);
				wd.free = 1'b1;
			end
			ffha_pkg::S_IDLE: begin
				sts.cond = !in_item.opcode;
				sts.cond2 = in_item.block_address > 13'(ffha_pkg::HeapBytes);
			end
			ffha_pkg::S_SCAN_CHK: begin
				sts.cond = req_q.opcode ? (hit_f && !rd.free) : hit_a;
				sts.cond2 = req_q.opcode ? (hit_f || i_q + 1'b1 >= used_q)
					: (i_q + 1'b1 >= used_q);
				if (req_q.opcode && hit_f && !rd.free) sts.cond2 = 1'b0;
				if (!req_q.opcode && hit_a) sts.cond2 = 1'b1;
				if (i_q == '0) ra = '0;
				else ra = i_q[ffha_pkg::IdxW-1:0] - 1'b1;
			end
			ffha_pkg::S_ALLOC_WR: begin
				we = 1'b1;
				wd.free = 1'b0;
				if (split) wd.size = rq;
				sts.cond = split;
			end
			ffha_pkg::S_SHU_RD: begin
				sts.cond = j_q > i_q + 1'b1;
				ra = j_q[ffha_pkg::IdxW-1:0] - 1'b1;
			end
			ffha_pkg::S_SHU_WR: begin
				we = 1'b1;
				wa = j_q[ffha_pkg::IdxW-1:0];
				wd = rd;
			end
			ffha_pkg::S_INS_WR: begin
				we = 1'b1;
				wa = i_q[ffha_pkg::IdxW-1:0] + 1'b1;
				wd = rest_q;
			end
			ffha_pkg::S_FREE_RDP: begin
				ra = i_q[ffha_pkg::IdxW-1:0] + 1'b1;
			end
			// hold the read of the next entry so it is still on rd in FREE_DEC
			ffha_pkg::S_FREE_RDN: begin
				ra = i_q[ffha_pkg::IdxW-1:0] + 1'b1;
			end
			ffha_pkg::S_FREE_DEC: begin
				we = 1'b1;
				sts.cond = pf_q || (nf_q);
				wd.free = 1'b1;
				if (pf_q) begin
					wa = i_q[ffha_pkg::IdxW-1:0] - 1'b1;
					wd = prv_q;
					wd.size = prv_q.size + cur_q.size + Hdr
						+ (nf_q ? rd.size + Hdr : '0);
				end else if (nf_q) begin
					wd.size = cur_q.size + rd.size + Hdr;
				end
			end
			ffha_pkg::S_DEL_RD: begin
				sts.cond = j_q + ffha_pkg::CntW'(ndel_q) < used_q;
				ra = ffha_pkg::IdxW'(j_q + ffha_pkg::CntW'(ndel_q));
			end
			ffha_pkg::S_DEL_WR: begin
				we = 1'b1;
				wa = j_q[ffha_pkg::IdxW-1:0];
				wd = rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= ffha_pkg::CntW'(1);
			done <= 1'b0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			done <= ctl.st == ffha_pkg::S_DONE;
			case (ctl.st)
				ffha_pkg::S_IDLE: begin
					i_q <= '0;
					if (start) begin
						req_q <= in_item;
						raddr_q <= '0;
						freed_q <= '0;
						stat_q <= in_item.opcode ? ffha_pkg::StOutside : ffha_pkg::StNoFit;
						if (in_item.opcode && in_item.block_address <= 13'(ffha_pkg::HeapBytes))
							stat_q <= ffha_pkg::StNotBlock;
					end
				end
				ffha_pkg::S_SCAN_CHK: begin
					cur_q <= rd;
					if (!sts.cond) i_q <= i_q + 1'b1;
					if (!req_q.opcode && hit_a) begin
						stat_q <= ffha_pkg::StAlloc;
						raddr_q <= 13'(rd.offset + Hdr);
					end
					if (req_q.opcode && hit_f && !rd.free) begin
						stat_q <= ffha_pkg::StFreed;
						freed_q <= rd.size[12:0];
					end
				end
				ffha_pkg::S_ALLOC_WR: begin
					rest_q.offset <= cur_q.offset + Hdr + rq;
					rest_q.size <= cur_q.size - rq - Hdr;
					rest_q.free <= 1'b1;
					j_q <= used_q;
				end
				ffha_pkg::S_SHU_WR: j_q <= j_q - 1'b1;
				ffha_pkg::S_INS_WR: used_q <= used_q + 1'b1;
				ffha_pkg::S_FREE_RDP: begin
					pf_q <= (i_q != '0) && rd.free;
					prv_q <= rd;
				end
				ffha_pkg::S_FREE_RDN: nf_q <= nf_now;
				ffha_pkg::S_FREE_DEC: begin
					ndel_q <= 2'(pf_q) + 2'(nf_q);
					j_q <= pf_q ? i_q : i_q + 1'b1;
				end
				ffha_pkg::S_DEL_RD: begin
					if (!sts.cond) used_q <= used_q - ffha_pkg::CntW'(ndel_q);
				end
				ffha_pkg::S_DEL_WR: j_q <= j_q + 1'b1;
				default: ;
			endcase
		end
	end

	assign out_item.status = stat_q;
	assign out_item.result_address = raddr_q;
	assign out_item.freed_size = freed_q;

	a_used_ok: assert property (@(posedge clk) disable iff (!arst_n)
		used_q != '0 && used_q <= Full) else $error("used count");
	a_split_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.st == ffha_pkg::S_INS_WR |-> used_q < Full) else $error("insert full");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done");
endmodule
`default_nettype wire

[hdl/first_fit_heap_allocator_top.sv]
// Top level of the first-fit heap allocator.
// One item at a time: an item is taken when start is high and busy is low, and its
// result appears with done for one cycle, while busy is already low. Time per item is
// set by the block table walk, each entry read and then checked, followed on a split
// or coalesce by a shift of the entries above the block, each entry read and then
// written. Walk and shift together pass over the table at most once. After reset, the
// table is set up in the INIT state. The receiver cannot stall.
`default_nettype none
module first_fit_heap_allocator_top (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  ffha_pkg::in_item_t   in_item,
	output logic                 busy,
	output logic                 done,
	output ffha_pkg::out_item_t  out_item
);
	ffha_pkg::ctl_t ctl;
	ffha_pkg::sts_t sts;

	ffha_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .ctl(ctl));
	ffha_dp u_dp (.clk(clk), .arst_n(arst_n), .start(start && !busy), .in_item(in_item),
		.ctl(ctl), .sts(sts), .done(done), .out_item(out_item));

	assign busy = ctl.st != ffha_pkg::S_IDLE;
endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the first-fit heap allocator: predicts each item's result and compares.
`default_nettype none
module tb_top;
	localparam int WatchLimit = 20 * ffha_pkg::MaxBlocks + 200;
	localparam int TailCycles = 4 * ffha_pkg::MaxBlocks + 20;

	typedef struct {
		int unsigned offset;
		int unsigned size;
		bit          is_free;
	} blk_t;

	class heap_scoreboard;
		blk_t                  blocks[$];
		ffha_pkg::out_item_t   pending[$];
		int                    errors;

		function new();
			errors = 0;
			blocks.delete();
			blocks.push_back('{0, ffha_pkg::HeapBytes - ffha_pkg::HeaderBytes, 1'b1});
		endfunction

		function void join_next(int idx);
			blocks[idx].size += blocks[idx + 1].size + ffha_pkg::HeaderBytes;
			blocks.delete(idx + 1);
		endfunction

		function void note_item(ffha_pkg::in_item_t it);
			ffha_pkg::out_item_t r;
			int i;
			int unsigned req, addr;
			bit pf, nf;
			blk_t rest;
			r = '0;
			req = it.request_size;
			addr = it.block_address;
			if (it.opcode == 1'b0) begin
				r.status = ffha_pkg::StNoFit;
				for (i = 0; i < blocks.size(); i++)
					if (blocks[i].is_free && blocks[i].size >= req) break;
				if (i < blocks.size()) begin
					blocks[i].is_free = 1'b0;
					if (blocks[i].size - req > ffha_pkg::HeaderBytes
						&& blocks.size() < ffha_pkg::MaxBlocks) begin
						rest.offset = blocks[i].offset + ffha_pkg::HeaderBytes + req;
						rest.size = blocks[i].size - req - ffha_pkg::HeaderBytes;
						rest.is_free = 1'b1;
						blocks[i].size = req;
						blocks.insert(i + 1, rest);
					end
					r.status = ffha_pkg::StAlloc;
					r.result_address = 13'(blocks[i].offset + ffha_pkg::HeaderBytes);
				end
			end else if (addr > ffha_pkg::HeapBytes) begin
				r.status = ffha_pkg::StOutside;
			end else begin
				r.status = ffha_pkg::StNotBlock;
				for (i = 0; i < blocks.size(); i++)
					if (blocks[i].offset + ffha_pkg::HeaderBytes == addr) break;
				if (i < blocks.size() && !blocks[i].is_free) begin
					pf = (i > 0) && blocks[i - 1].is_free;
					nf = (i + 1 < blocks.size()) && blocks[i + 1].is_free;
					r.freed_size = 13'(blocks[i].size);
					r.status = ffha_pkg::StFreed;
					blocks[i].is_free = 1'b1;
					if (pf && nf) begin
						join_next(i - 1);
						join_next(i - 1);
					end else if (pf) join_next(i - 1);
					else if (nf) join_next(i);
				end
			end
			pending.push_back(r);
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_result(ffha_pkg::out_item_t got);
			ffha_pkg::out_item_t want;
			if (pending.size() == 0) begin
				report("result with none expected");
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d want %0d", got.status, want.status));
			if (got.result_address !== want.result_address)
				report($sformatf("address %0d want %0d", got.result_address, want.result_address));
			if (got.freed_size !== want.freed_size)
				report($sformatf("freed %0d want %0d", got.freed_size, want.freed_size));
		endtask

		// live allocated payload offsets, for well-formed frees
		function int unsigned pick_live();
			int unsigned cand[$];
			foreach (blocks[k])
				if (!blocks[k].is_free) cand.push_back(blocks[k].offset + ffha_pkg::HeaderBytes);
			if (cand.size() == 0) return ffha_pkg::HeaderBytes;
			return cand[$urandom_range(cand.size() - 1)];
		endfunction
	endclass

	logic clk = 1'b0, arst_n = 1'b0, start = 1'b0;
	ffha_pkg::in_item_t in_item = '0;
	logic busy, done;
	ffha_pkg::out_item_t out_item;
	heap_scoreboard sb;
	int idle_cycles = 0;
	bit quiet = 1'b0;

	first_fit_heap_allocator_top u_dut (.clk, .arst_n, .start, .in_item, .busy, .done, .out_item);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (done) sb.check_result(out_item);
		if ((start && !busy) || done) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WatchLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	// start stays high after the item is taken until the next idle or drain
	task automatic send(bit op, int unsigned req, int unsigned addr);
		ffha_pkg::in_item_t it;
		it.opcode = op;
		it.request_size = 13'(req);
		it.block_address = 13'(addr);
		while (!quiet && $urandom_range(99) < 10) begin
			start <= 1'b0;
			in_item <= ffha_pkg::in_item_t'(27'($urandom));
			@(posedge clk);
		end
		start <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_item(it);
	endtask

	task automatic drain();
		start <= 1'b0;
		in_item <= ffha_pkg::in_item_t'(27'($urandom));
		do @(posedge clk); while (sb.pending.size() != 0);
	endtask

	task automatic random_item();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50) send(1'b0, ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(200),
			$urandom);
		else if (r < 85) send(1'b1, $urandom, sb.pick_live());
		else if (r < 93) send(1'b1, $urandom, $urandom_range(ffha_pkg::HeapBytes));
		else send(1'b1, $urandom, $urandom_range(8191));
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed
		send(1'b0, 0, 0);
		send(1'b0, 8191, 0);
		send(1'b0, ffha_pkg::HeapBytes - 2 * ffha_pkg::HeaderBytes - 16, 8191);
		send(1'b1, 0, ffha_pkg::HeaderBytes);
		send(1'b1, 0, ffha_pkg::HeaderBytes);
		send(1'b1, 0, ffha_pkg::HeapBytes + 1);
		send(1'b1, 0, 8191);
		send(1'b1, 0, ffha_pkg::HeapBytes);
		send(1'b1, 0, 0);
		send(1'b0, ffha_pkg::HeapBytes - ffha_pkg::HeaderBytes, 0);
		send(1'b1, 8191, ffha_pkg::HeaderBytes);
		send(1'b0, 100, 0);
		send(1'b0, 100, 0);
		send(1'b0, 100, 0);
		send(1'b1, 0, 2 * ffha_pkg::HeaderBytes + 100);
		send(1'b1, 0, ffha_pkg::HeaderBytes);
		send(1'b1, 0, 3 * ffha_pkg::HeaderBytes + 200);
		send(1'b1, 0, 4 * ffha_pkg::HeaderBytes + 300);
		drain();
		// fill the table with zero-byte blocks, then free 40 of them back
		for (int k = 0; k < ffha_pkg::MaxBlocks + 2; k++) send(1'b0, 0, 0);
		send(1'b0, 0, 0);
		for (int k = 0; k < 40; k++) send(1'b1, 0, sb.pick_live());
		drain();
		for (int k = 0; k < 1100; k++) begin
			quiet = (k >= 500 && k < 700);
			if (k == 900) drain();
			random_item();
		end
		drain();
		repeat (TailCycles) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire

[sim.f]
hdl/ffha_pkg.sv
hdl/ffha_ram.sv
hdl/ffha_ctrl.sv
hdl/ffha_dp.sv
hdl/first_fit_heap_allocator_top.sv
bench/tb_top.sv
